// ===== rtl/stream_find_replace_macros.svh =====
// Assertion helpers for the find-and-replace block.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned ReplaceMax = 8;
  localparam int unsigned CntW       = $clog2(PatternMax + 1);
  localparam int unsigned HeldIdxW   = $clog2(PatternMax);
  localparam int unsigned RepIdxW    = $clog2(ReplaceMax);

  typedef enum logic [2:0] {
    CFG_SEARCH_PATTERN     = 3'd0,
    CFG_SEARCH_LENGTH      = 3'd1,
    CFG_REPLACEMENT_TEXT   = 3'd2,
    CFG_REPLACEMENT_LENGTH = 3'd3
  } cfg_index_e;

  // Controller to datapath
  typedef struct packed {
    logic append;      // store the incoming byte at the tail
    logic emit_held;   // send the oldest held byte and shift
    logic emit_rep;    // send the next replacement byte
    logic emit_empty;  // send an empty closing word
    logic last;        // mark the word being sent as last of text
    logic match;       // count a match and drop the held bytes
    logic end_text;    // reset held count and match total
  } sfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic prefix;      // held bytes agree with the head of the pattern
    logic full;        // as many held bytes as the pattern is long
    logic rep_zero;
    logic rep_last;
    logic out_free;    // output register can take a word this cycle
  } sfr_status_t;

  function automatic logic [3:0] eff_search_len(input logic [3:0] len);
    logic [3:0] n;
    n = len;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(PatternMax)) n = 4'(PatternMax);
    return n;
  endfunction

  function automatic logic [3:0] eff_repl_len(input logic [3:0] len);
    logic [3:0] n;
    n = len;
    if (n > 4'(ReplaceMax)) n = 4'(ReplaceMax);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sfr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath import sfr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire sfr_cmd_t           cmd_i,
  output sfr_status_t             status_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    out_byte_valid_o,
  output logic                    out_last_o,
  output logic [15:0]             out_count_o
);

  logic [63:0]        pat_q, rep_q;
  logic [3:0]         slen_q, rlen_q;
  logic [3:0]         slen, rlen;
  logic [7:0]         held_q [PatternMax];
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [15:0]        total_q, total_d;
  logic [RepIdxW-1:0] rep_idx_q, rep_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q;
  logic               out_bv_q, out_last_q;
  logic [15:0]        out_count_q;
  logic [PatternMax-1:0] mismatch;
  logic               load;
  logic [7:0]         rep_byte;

  assign slen = eff_search_len(slen_q);
  assign rlen = eff_repl_len(rlen_q);

  always_comb begin
    for (int i = 0; i < PatternMax; i++) begin
      mismatch[i] = (CntW'(i) < cnt_q) && (held_q[i] != pat_q[8*i +: 8]);
    end
  end

  assign rep_byte = rep_q[8*rep_idx_q +: 8];

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cnt_one  = (cnt_q == CntW'(1));
  assign status_o.prefix   = ~|mismatch;
  assign status_o.full     = (4'(cnt_q) >= slen);
  assign status_o.rep_zero = (rlen == 4'd0);
  assign status_o.rep_last = ((4'(rep_idx_q) + 4'd1) == rlen);
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  assign load = cmd_i.emit_held | cmd_i.emit_rep | cmd_i.emit_empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      slen_q <= 4'd1;
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEARCH_PATTERN:     pat_q  <= cfg_data_i;
        CFG_SEARCH_LENGTH:      slen_q <= cfg_data_i[3:0];
        CFG_REPLACEMENT_TEXT:   rep_q  <= cfg_data_i;
        CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.end_text || cmd_i.match) begin
      cnt_d = '0;
    end else if (cfg_we_i && (cfg_index_i == CFG_SEARCH_PATTERN ||
                              cfg_index_i == CFG_SEARCH_LENGTH)) begin
      cnt_d = '0;
    end else if (cmd_i.append && cnt_q < CntW'(PatternMax)) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.emit_held) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    total_d = total_q;
    if (cmd_i.end_text) begin
      total_d = '0;
    end else if (cmd_i.match && total_q != 16'hFFFF) begin
      total_d = total_q + 16'd1;
    end
  end

  always_comb begin
    rep_idx_d = rep_idx_q;
    if (cmd_i.match) begin
      rep_idx_d = '0;
    end else if (cmd_i.emit_rep) begin
      rep_idx_d = rep_idx_q + RepIdxW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= '0;
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      rep_idx_q   <= rep_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Held bytes: append at the tail, shift towards the head on release
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && cnt_q < CntW'(PatternMax)) begin
      held_q[cnt_q[HeldIdxW-1:0]] <= in_byte_i;
    end else if (cmd_i.emit_held) begin
      for (int i = 0; i < PatternMax - 1; i++) begin
        held_q[i] <= held_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_bv_q    <= ~cmd_i.emit_empty;
      out_last_q  <= cmd_i.last;
      out_count_q <= total_q;
      priority if (cmd_i.emit_held) begin
        out_byte_q <= held_q[0];
      end else if (cmd_i.emit_rep) begin
        out_byte_q <= rep_byte;
      end else begin
        out_byte_q <= 8'd0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_bv_q;
  assign out_last_o       = out_last_q;
  assign out_count_o      = out_count_q;

endmodule

`default_nettype wire

// ===== rtl/sfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_last_i,
  output logic              in_ready_o,
  input  wire sfr_status_t  status_i,
  output sfr_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_REP   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_last_i) begin
            state_d = ST_FLUSH;
          end else begin
            cmd_o.append = 1'b1;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        priority if (status_i.cnt_zero) begin
          state_d = ST_IDLE;
        end else if (status_i.prefix) begin
          if (status_i.full) begin
            cmd_o.match = 1'b1;
            state_d     = status_i.rep_zero ? ST_IDLE : ST_REP;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (status_i.out_free) begin
          // release the oldest byte and test the rest again
          cmd_o.emit_held = 1'b1;
        end
      end
      ST_REP: begin
        if (status_i.out_free) begin
          cmd_o.emit_rep = 1'b1;
          if (status_i.rep_last) state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          if (status_i.cnt_zero) begin
            cmd_o.emit_empty = 1'b1;
            cmd_o.last       = 1'b1;
            cmd_o.end_text   = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            cmd_o.emit_held = 1'b1;
            if (status_i.cnt_one) begin
              cmd_o.last     = 1'b1;
              cmd_o.end_text = 1'b1;
              state_d        = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stream_find_replace.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming find-and-replace-all over a byte stream. Each input word is one
// source byte, or with tlast set the end of the text. Every leftmost,
// non-overlapping occurrence of the search pattern (1 to 8 bytes) is replaced
// by the replacement text (0 to 8 bytes); bytes that could still begin a match
// are held back until they are resolved. Output tuser is 1 when the word
// carries a byte; the end of text flushes the held bytes and the final word
// has tlast set (an empty word with tuser 0 when nothing was held) and carries
// the saturating replacement count in its upper bits. An input byte is first
// accepted, then checked as a prefix, then releases any held or replacement
// bytes it frees, up to eight; the end item sends the held bytes, or an empty
// word when nothing was held. No new input word is taken until the last one is
// through. The controller sends one word a cycle through the single output
// register while the output is not stalled. Write the configuration only
// while the block is idle; a write to the search pattern or search length
// drops any held bytes.
module stream_find_replace import sfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] replace_count
  output logic             m_axis_tuser,   // byte_valid
  output logic             m_axis_tlast    // last_of_text
);

  sfr_cmd_t    cmd;
  sfr_status_t status;
  logic [7:0]  out_byte;
  logic [15:0] out_count;

  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfr_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_byte_i        (s_axis_tdata),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_byte_o       (out_byte),
    .out_byte_valid_o (m_axis_tuser),
    .out_last_o       (m_axis_tlast),
    .out_count_o      (out_count)
  );

  assign m_axis_tdata = {out_count, out_byte};

endmodule

`default_nettype wire

// ===== rtl/sfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "stream_find_replace_macros.svh"

module sfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // An empty word only closes a text, and then carries no byte
  `SFR_ASSERT_NOW(a_empty_is_close, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
  // Every accepted word is worked on before the next one is taken
  `SFR_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SFR_ASSERT_NEXT(a_out_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SFR_ASSERT_NEXT(a_out_hold_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
